@@ src/rwed_pkg.sv @@
package rwed_pkg;

  localparam int MAX_SAMPLES_DEF = 1024;

  // Readout word fields
  localparam logic [15:0] HDR_BIT      = 16'h8000;
  localparam logic [15:0] SIGN_BIT     = 16'h0800;
  localparam logic [15:0] SAMPLE_MASK  = 16'h0fff;
  localparam int          WORD_W       = 16;
  localparam int          TS_W         = 48;

  // Configuration register indexes
  localparam logic CFG_HEADER_MASK  = 1'b0;
  localparam logic CFG_HEADER_MATCH = 1'b1;

  localparam logic [15:0] HEADER_MASK_RST  = 16'h8000;
  localparam logic [15:0] HEADER_MATCH_RST = 16'h8000;

  // Result kinds
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_BAD_HEADER = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW   = 2'd1;
  localparam logic [1:0] ERR_TRUNC_TS   = 2'd2;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TS0,
    PH_TS1,
    PH_TS2,
    PH_DATA,
    PH_HALT
  } phase_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        event_flags;
    logic [47:0]        timestamp;
    logic signed [11:0] sample_value;
    logic [2:0]         sample_flag;
    logic [9:0]         sample_index;
    logic [10:0]        event_length;
    logic [1:0]         error_code;
    logic               last;
  } res_t;

  // Results produced by one accepted word, up to two
  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

@@ src/rwed_res_queue.sv @@
module rwed_res_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  rwed_pkg::push_t push,
  input  logic          pop,
  output rwed_pkg::res_t head,
  output logic          head_valid,
  output logic          room_for_two
);
  import rwed_pkg::*;

  localparam int DEPTH = 3;

  res_t       slot_r [DEPTH];
  res_t       slot_nxt [DEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] base;

  always_comb begin
    base = cnt_r - {1'b0, pop};
    slot_nxt[0] = pop ? slot_r[1] : slot_r[0];
    slot_nxt[1] = pop ? slot_r[2] : slot_r[1];
    slot_nxt[2] = slot_r[2];
    for (int i = 0; i < DEPTH; i++) begin
      if (push.num != 2'd0 && base == 2'(i)) begin
        slot_nxt[i] = push.first;
      end
      if (push.num == 2'd2 && base + 2'd1 == 2'(i)) begin
        slot_nxt[i] = push.second;
      end
    end
    cnt_nxt = base + push.num;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  assign head         = slot_r[0];
  assign head_valid   = (cnt_r != 2'd0);
  assign room_for_two = (cnt_r <= 2'd1);

endmodule

@@ src/readout_word_event_deframer.sv @@
// Readout word event deframer: one 16-bit word accepted per cycle while
// in_ready is high, i.e. while the three-slot result queue has room for two
// results, so a word with two results can hold off the next. Results of an
// accepted word go into that registered queue, whose head drives the output.
// Reset (rst_n, synchronous, active low): awaits a header, queue empty,
// header_mask and header_match back to 0x8000.
module readout_word_event_deframer #(
  parameter int MAX_SAMPLES = rwed_pkg::MAX_SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input words
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_data_word,
  input  logic               in_end_of_stream,
  // results
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [15:0]        out_event_flags,
  output logic [47:0]        out_timestamp,
  output logic signed [11:0] out_sample_value,
  output logic [2:0]         out_sample_flag,
  output logic [9:0]         out_sample_index,
  output logic [10:0]        out_event_length,
  output logic [1:0]         out_error_code,
  output logic               out_last,
  // configuration writes
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import rwed_pkg::*;

  // count runs 0..MAX_SAMPLES inclusive
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  logic [15:0]   hdr_mask_r, hdr_match_r;
  phase_t        phase_r, phase_nxt;
  logic [15:0]   hdr_word_r, hdr_word_nxt;
  logic [47:0]   ts_r, ts_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic          in_acc;
  logic          hdr_ok;
  logic          is_hdr;
  logic          full;
  logic [47:0]   ts_shift;
  logic [CW-1:0] cnt_inc;
  logic [31:0]   cnt_ext, cnt_inc_ext;

  push_t         push;
  res_t          head;
  logic          head_valid;
  logic          room_for_two;
  logic          pop;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_mask_r  <= HEADER_MASK_RST;
      hdr_match_r <= HEADER_MATCH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_MASK:  hdr_mask_r  <= cfg_wdata;
        CFG_HEADER_MATCH: hdr_match_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Word decode, shared by both blocks below
  // ---------------------------------------------------------------------------
  assign in_acc      = in_valid & in_ready;
  assign hdr_ok      = (in_data_word & hdr_mask_r) == hdr_match_r;
  assign is_hdr      = (in_data_word & HDR_BIT) != 16'h0000;
  assign full        = (cnt_r >= CW'(MAX_SAMPLES));
  assign ts_shift    = {ts_r[TS_W-WORD_W-1:0], in_data_word};
  assign cnt_inc     = cnt_r + CW'(1);
  assign cnt_ext     = 32'(cnt_r);
  assign cnt_inc_ext = 32'(cnt_inc);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_nxt    = phase_r;
    hdr_word_nxt = hdr_word_r;
    ts_nxt       = ts_r;
    cnt_nxt      = cnt_r;
    if (in_acc) begin
      case (phase_r)
        PH_HEADER: begin
          if (!hdr_ok || in_end_of_stream) begin
            phase_nxt = PH_HALT;
          end else begin
            phase_nxt    = PH_TS0;
            hdr_word_nxt = in_data_word;
            ts_nxt       = '0;
            cnt_nxt      = '0;
          end
        end
        PH_TS0, PH_TS1: begin
          ts_nxt = ts_shift;
          if (in_end_of_stream) begin
            phase_nxt = PH_HALT;
          end else begin
            phase_nxt = (phase_r == PH_TS0) ? PH_TS1 : PH_TS2;
          end
        end
        PH_TS2: begin
          ts_nxt    = ts_shift;
          phase_nxt = in_end_of_stream ? PH_HEADER : PH_DATA;
        end
        PH_DATA: begin
          if (!is_hdr) begin
            if (full) begin
              phase_nxt = PH_HALT;
            end else begin
              cnt_nxt = cnt_inc;
              if (in_end_of_stream) begin
                phase_nxt = PH_HEADER;
              end
            end
          end else if (!hdr_ok || in_end_of_stream) begin
            // event closed, then the new header fails or the stream stops
            phase_nxt = PH_HALT;
          end else begin
            phase_nxt    = PH_TS0;
            hdr_word_nxt = in_data_word;
            ts_nxt       = '0;
            cnt_nxt      = '0;
          end
        end
        PH_HALT: phase_nxt = PH_HALT;
        default: phase_nxt = PH_HALT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hdr_word_r <= '0;
      ts_r       <= '0;
      cnt_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      hdr_word_r <= hdr_word_nxt;
      ts_r       <= ts_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Results of the accepted word; unused fields stay zero
  // ---------------------------------------------------------------------------
  always_comb begin
    push        = '0;
    push.first  = '0;
    push.second = '0;
    case (phase_r)
      PH_HEADER: begin
        push.num              = 2'd1;
        push.first.kind       = KIND_ERROR;
        push.first.error_code = hdr_ok ? ERR_TRUNC_TS : ERR_BAD_HEADER;
        push.first.last       = 1'b1;
        if (hdr_ok && !in_end_of_stream) begin
          push.num = 2'd0;
        end
      end
      PH_TS0, PH_TS1: begin
        if (in_end_of_stream) begin
          push.num              = 2'd1;
          push.first.kind       = KIND_ERROR;
          push.first.error_code = ERR_TRUNC_TS;
          push.first.last       = 1'b1;
        end
      end
      PH_TS2: begin
        // event start goes out with the last timestamp word
        push.first.kind        = KIND_START;
        push.first.event_flags = hdr_word_r;
        push.first.timestamp   = ts_shift;
        if (in_end_of_stream) begin
          push.num         = 2'd2;
          push.second.kind = KIND_END;
          push.second.last = 1'b1;
        end else begin
          push.num        = 2'd1;
          push.first.last = 1'b1;
        end
      end
      PH_DATA: begin
        if (!is_hdr) begin
          if (full) begin
            push.num              = 2'd1;
            push.first.kind       = KIND_ERROR;
            push.first.error_code = ERR_OVERFLOW;
            push.first.last       = 1'b1;
          end else begin
            push.first.kind         = KIND_SAMPLE;
            push.first.sample_value = $signed(in_data_word[11:0]);
            push.first.sample_flag  = in_data_word[14:12];
            push.first.sample_index = cnt_ext[9:0];
            if (in_end_of_stream) begin
              push.num                 = 2'd2;
              push.second.kind         = KIND_END;
              push.second.event_length = cnt_inc_ext[10:0];
              push.second.last         = 1'b1;
            end else begin
              push.num        = 2'd1;
              push.first.last = 1'b1;
            end
          end
        end else begin
          // header word: close this event, then check it as the next header
          push.first.kind         = KIND_END;
          push.first.event_length = cnt_ext[10:0];
          push.second.kind        = KIND_ERROR;
          push.second.error_code  = hdr_ok ? ERR_TRUNC_TS : ERR_BAD_HEADER;
          push.second.last        = 1'b1;
          if (hdr_ok && !in_end_of_stream) begin
            push.num        = 2'd1;
            push.first.last = 1'b1;
          end else begin
            push.num = 2'd2;
          end
        end
      end
      PH_HALT: push.num = 2'd0;
      default: push.num = 2'd0;
    endcase
    if (!in_acc) begin
      push.num = 2'd0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue: takes a word only with room for both of its results
  // ---------------------------------------------------------------------------
  assign pop = head_valid & out_ready;

  rwed_res_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .pop          (pop),
    .head         (head),
    .head_valid   (head_valid),
    .room_for_two (room_for_two)
  );

  assign in_ready         = room_for_two;
  assign out_valid        = head_valid;
  assign out_kind         = head.kind;
  assign out_event_flags  = head.event_flags;
  assign out_timestamp    = head.timestamp;
  assign out_sample_value = head.sample_value;
  assign out_sample_flag  = head.sample_flag;
  assign out_sample_index = head.sample_index;
  assign out_event_length = head.event_length;
  assign out_error_code   = head.error_code;
  assign out_last         = head.last;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import rwed_pkg::*;

  // Sample store depth of the block as built here
  localparam int SAMPLE_CAP = MAX_SAMPLES_DEF;

  // Ways of ending the run in the halted state. Reset comes only once,
  // so one of them is picked per run by the simulator seed.
  typedef enum int {
    STOP_BAD_HDR,
    STOP_BAD_HDR_IN_EVENT,
    STOP_EOS_ON_HDR,
    STOP_EOS_HDR_IN_EVENT,
    STOP_EOS_IN_TS,
    STOP_OVERFLOW
  } stop_case_t;

  stop_case_t stop_sel;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        in_data_word = '0;
  logic               in_end_of_stream = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_kind;
  logic [15:0]        out_event_flags;
  logic [47:0]        out_timestamp;
  logic signed [11:0] out_sample_value;
  logic [2:0]         out_sample_flag;
  logic [9:0]         out_sample_index;
  logic [10:0]        out_event_length;
  logic [1:0]         out_error_code;
  logic               out_last;
  logic               cfg_we = 1'b0;
  logic               cfg_index = CFG_HEADER_MASK;
  logic [15:0]        cfg_wdata = '0;

  readout_word_event_deframer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_word     (in_data_word),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_event_flags  (out_event_flags),
    .out_timestamp    (out_timestamp),
    .out_sample_value (out_sample_value),
    .out_sample_flag  (out_sample_flag),
    .out_sample_index (out_sample_index),
    .out_event_length (out_event_length),
    .out_error_code   (out_error_code),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Deframer state as the testbench sees it, plus its copy of the header
  // check registers.
  // ---------------------------------------------------------------------
  phase_t      ph = PH_HEADER;
  logic [15:0] hdr_word = '0;
  logic [47:0] ts_acc = '0;
  int          n_samp = 0;
  logic [15:0] hdr_mask = HEADER_MASK_RST;
  logic [15:0] hdr_match = HEADER_MATCH_RST;

  res_t due_results[$];   // results still owed by the block, oldest first
  res_t want_r;
  int   mismatch_count = 0;
  int   words_sent = 0;

  // Pacing knobs: steady = no random gaps on that side; rx_hold requests
  // one long stall of the receiver.
  bit   tx_steady = 1'b0;
  bit   rx_steady = 1'b0;
  int   rx_hold = 0;

  function automatic res_t blank_result(logic [1:0] k);
    res_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  // Header check; fills r and returns 1 when the word ends the stream in error.
  function automatic int check_header(logic [15:0] w, logic eos, output res_t r);
    r = '0;
    if ((w & hdr_mask) != hdr_match) begin
      r = blank_result(KIND_ERROR);
      r.error_code = ERR_BAD_HEADER;
      ph = PH_HALT;
      return 1;
    end
    if (eos) begin
      // good header but nothing left for the timestamp
      r = blank_result(KIND_ERROR);
      r.error_code = ERR_TRUNC_TS;
      ph = PH_HALT;
      return 1;
    end
    hdr_word = w;
    ts_acc = '0;
    n_samp = 0;
    ph = PH_TS0;
    return 0;
  endfunction

  // Advances the state by one accepted word and queues what it should yield.
  function automatic void deframe_word(logic [15:0] w, logic eos);
    res_t r0;
    res_t r1;
    int   n;
    r0 = '0;
    r1 = '0;
    n = 0;
    case (ph)
      PH_HEADER: n = check_header(w, eos, r0);
      PH_TS0, PH_TS1: begin
        ts_acc = {ts_acc[31:0], w};
        if (eos) begin
          r0 = blank_result(KIND_ERROR);
          r0.error_code = ERR_TRUNC_TS;
          ph = PH_HALT;
          n = 1;
        end else begin
          ph = (ph == PH_TS0) ? PH_TS1 : PH_TS2;
        end
      end
      PH_TS2: begin
        // event start waits for the last timestamp word
        ts_acc = {ts_acc[31:0], w};
        r0 = blank_result(KIND_START);
        r0.event_flags = hdr_word;
        r0.timestamp = ts_acc;
        n = 1;
        if (eos) begin
          r1 = blank_result(KIND_END);
          n = 2;
          ph = PH_HEADER;
        end else begin
          ph = PH_DATA;
        end
      end
      PH_DATA: begin
        if ((w & HDR_BIT) == '0) begin
          if (n_samp >= SAMPLE_CAP) begin
            r0 = blank_result(KIND_ERROR);
            r0.error_code = ERR_OVERFLOW;
            ph = PH_HALT;
            n = 1;
          end else begin
            r0 = blank_result(KIND_SAMPLE);
            r0.sample_value = w[11:0];
            r0.sample_flag = w[14:12];
            r0.sample_index = n_samp[9:0];
            n_samp++;
            n = 1;
            if (eos) begin
              r1 = blank_result(KIND_END);
              r1.event_length = n_samp[10:0];
              n = 2;
              ph = PH_HEADER;
            end
          end
        end else begin
          // header bit set: close the event, then judge the word as a header
          r0 = blank_result(KIND_END);
          r0.event_length = n_samp[10:0];
          n = 1 + check_header(w, eos, r1);
        end
      end
      default: n = 0;   // halted: word is dropped
    endcase
    if (n == 1) begin
      r0.last = 1'b1;
      due_results.push_back(r0);
    end else if (n == 2) begin
      r1.last = 1'b1;
      due_results.push_back(r0);
      due_results.push_back(r1);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Offers one word after a random gap and holds it until accepted.
  // Called and returns at a rising edge.
  task automatic send_word(logic [15:0] w, logic eos);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_word <= w;
    in_end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    deframe_word(w, eos);
  endtask

  // Random header that passes the current check; bit 15 set when allowed so
  // that it can also close a running event.
  function automatic logic [15:0] good_header();
    logic [15:0] h;
    h = (16'($urandom) & ~hdr_mask) | (hdr_match & hdr_mask);
    if (!hdr_mask[15])
      h[15] = 1'b1;
    return h;
  endfunction

  // With bit 15 forced low in every header, an event can only close on
  // end of stream.
  function automatic bit headers_lack_hdr_bit();
    return hdr_mask[15] && !hdr_match[15];
  endfunction

  // Header, three timestamp words, n samples; close puts end of stream on
  // the last word.
  task automatic send_event(int n, bit close);
    int k;
    send_word(good_header(), 1'b0);
    for (k = 0; k < 3; k++)
      send_word(16'($urandom), close && n == 0 && k == 2);
    for (k = 0; k < n; k++)
      send_word({1'b0, 15'($urandom)}, close && k == n - 1);
  endtask

  // Leaves the block awaiting a header.
  task automatic finish_stream();
    if (ph == PH_DATA)
      send_word({1'b0, 15'($urandom)}, 1'b1);
  endtask

  // Sender pause: nothing offered until every owed result has come back,
  // then a further wait for words that yield nothing.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(logic [15:0] mask, logic [15:0] match);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= CFG_HEADER_MASK;
    cfg_wdata <= mask;
    @(posedge clk);
    hdr_mask = mask;
    cfg_index <= CFG_HEADER_MATCH;
    cfg_wdata <= match;
    @(posedge clk);
    hdr_match = match;
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stall per result, optional long hold.
  // ---------------------------------------------------------------------
  initial begin : rx_side
    int stall;
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 6);
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: result kind %0d with none expected", $time, out_kind);
        mismatch_count++;
      end else begin
        want_r = due_results.pop_front();
        check_field("kind", want_r.kind, out_kind);
        check_field("event_flags", want_r.event_flags, out_event_flags);
        check_field("timestamp", want_r.timestamp, out_timestamp);
        check_field("sample_value", want_r.sample_value, out_sample_value);
        check_field("sample_flag", want_r.sample_flag, out_sample_flag);
        check_field("sample_index", want_r.sample_index, out_sample_index);
        check_field("event_length", want_r.event_length, out_event_length);
        check_field("error_code", want_r.error_code, out_error_code);
        check_field("last", want_r.last, out_last);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Hand-picked words under the reset header check: extreme timestamps and
  // samples, event closed by a header, by end of stream on the last
  // timestamp word and on a data word, and an empty event closed by a header.
  task automatic test_directed();
    send_word(16'h8000, 1'b0);
    send_word(16'hffff, 1'b0);
    send_word(16'hffff, 1'b0);
    send_word(16'hffff, 1'b0);
    send_word(16'h0000, 1'b0);   // zero sample, flag 0
    send_word(16'h7fff, 1'b0);   // -1, flag 7
    send_word(16'h0800, 1'b0);   // most negative
    send_word(16'h07ff, 1'b0);   // most positive
    send_word(16'hffff, 1'b0);   // closes with length 4, opens next
    send_word(16'h0000, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h0000, 1'b1);   // start then zero-length end
    send_word(16'hc3a5, 1'b0);
    send_word(16'h1234, 1'b0);
    send_word(16'h5678, 1'b0);
    send_word(16'h9abc, 1'b0);
    send_word(16'h5a5a, 1'b1);   // sample then end
    send_word(16'h8001, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'h0002, 1'b0);
    send_word(16'h0003, 1'b0);
    send_word(16'hfffe, 1'b0);   // empty event closed by a header
    send_word(16'h0fff, 1'b0);
    send_word(16'hf000, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h7800, 1'b1);
  endtask

  // Random small events across several header check settings, extremes
  // among them.
  task automatic test_random_events();
    int          i;
    int          start;
    int          n;
    bit          close;
    logic [15:0] mask;
    logic [15:0] match;
    for (i = 0; i < 6; i++) begin
      case (i)
        0: begin mask = HEADER_MASK_RST; match = HEADER_MATCH_RST; end
        1: begin mask = 16'hffff; match = 16'hffff; end
        2: begin mask = 16'h0000; match = 16'h0000; end
        3: begin mask = 16'hffff; match = 16'h0000; end
        4: begin mask = {1'b1, 15'($urandom)}; match = {1'b1, 15'($urandom)}; end
        default: begin mask = 16'($urandom); match = 16'($urandom); end
      endcase
      // match bits outside the mask would reject every header
      match = match & mask;
      write_config(mask, match);
      start = words_sent;
      while (words_sent - start < 45) begin
        tx_steady = ($urandom_range(0, 4) == 0);
        rx_steady = ($urandom_range(0, 4) == 0);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
        close = headers_lack_hdr_bit() || ($urandom_range(0, 2) == 0);
        send_event(n, close);
      end
      finish_stream();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // One event filling the whole sample store; length 1024 in the end result.
  // When the run is to stop on overflow, the full event is left open.
  task automatic test_full_event();
    logic [15:0] mask;
    mask = 16'($urandom) | HDR_BIT;
    write_config(mask, (16'($urandom) | HDR_BIT) & mask);
    if (stop_sel == STOP_OVERFLOW) begin
      send_event(SAMPLE_CAP, 1'b0);
    end else begin
      send_event(SAMPLE_CAP, $urandom_range(0, 1) == 1);
      send_event(2, 1'b1);
    end
  endtask

  // Receiver holds off long enough for the block to fill and stall its
  // input; later the sender stops mid-event until everything has drained.
  task automatic test_stalls();
    rx_hold = 150;
    tx_steady = 1'b1;
    send_event(40, 1'b0);
    send_event(3, 1'b0);
    tx_steady = 1'b0;
    wait_drained();
    send_event(4, 1'b1);
  endtask

  // Ends the run in the halted state by one of the error paths, then
  // checks that further words are dropped.
  task automatic test_halt();
    stop_case_t  sc;
    logic [15:0] mask;
    mask = {1'b1, 15'($urandom) | 15'h0001};   // bit 0 checked: bad header exists
    write_config(mask, {1'b1, 15'($urandom)} & mask);
    sc = stop_sel;
    case (sc)
      STOP_BAD_HDR: send_word(good_header() ^ 16'h0001, $urandom_range(0, 1) == 1);
      STOP_BAD_HDR_IN_EVENT: begin
        send_event($urandom_range(0, 5), 1'b0);
        send_word(good_header() ^ 16'h0001, $urandom_range(0, 1) == 1);
      end
      STOP_EOS_ON_HDR: send_word(good_header(), 1'b1);
      STOP_EOS_HDR_IN_EVENT: begin
        send_event($urandom_range(0, 5), 1'b0);
        send_word(good_header(), 1'b1);
      end
      STOP_EOS_IN_TS: begin
        send_word(good_header(), 1'b0);
        if ($urandom_range(0, 1) == 0) begin
          send_word(16'($urandom), 1'b1);
        end else begin
          send_word(16'($urandom), 1'b0);
          send_word(16'($urandom), 1'b1);
        end
      end
      default: begin
        // store already full from the open event
        send_word({1'b0, 15'($urandom)}, $urandom_range(0, 1) == 1);
      end
    endcase
    repeat (8) send_word(16'($urandom), $urandom_range(0, 1) == 1);
  endtask

  initial begin
    stop_sel = stop_case_t'($urandom_range(0, 5));
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_events();
    test_stalls();
    test_full_event();
    test_halt();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #800000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
